// File: rtl/sblt_pkg.sv
`default_nettype none

package sblt_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// field widths
	localparam int DATA_W      = 32;
	localparam int POS_W       = 6;
	localparam int HELD_W      = 7;
	localparam int CAP_W       = 7;
	localparam int OUT_TDATA_W = 16;

	// width used to saturate the capacity register against the depth
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	// request kinds
	localparam logic ACT_FIND = 1'b0;
	localparam logic ACT_ADD  = 1'b1;

	// result word handed from the engine to the output register
	typedef struct packed {
		logic              found;
		logic [POS_W-1:0]  position;
		logic              add_ok;
		logic [HELD_W-1:0] entries_held;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/sorted_block_list_table_core.sv
// sorted block list table
//
// keeps up to TABLE_DEPTH signed 32-bit block numbers in ascending order,
// no duplicates. one request word in, one result word out.
// s_axis: tdata = block number, tuser = action (0 find, 1 add)
// m_axis: tdata = found, position, add_ok, entries_held (lsb first)
// cfg_wr_en / cfg_wr_data write the capacity limit, any time the block is idle
// a single compare unit walks the valid entries one per cycle over a registered
// read port; a find stops at a hit or after the last entry. an add that inserts
// moves the larger entries up one slot per cycle and then places the new one;
// otherwise it appends after the last entry or stops at an equal entry. an add
// with the count at the capacity limit is rejected; a find on an empty table
// and an add to an empty table skip the scan. the result word becomes valid in
// the same cycle that the engine returns to idle and can take the next request.
// one request in flight; s_axis_tready is high only while the engine is idle.
// the result sits in an output register; a stalled receiver holds the engine
// in its finishing step until the word is taken. reset empties the table
// (count to zero) and sets the capacity to 64; contents are not cleared.
`default_nettype none

module sorted_block_list_table_core
	import sblt_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// request word
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [DATA_W-1:0]      s_axis_tdata,   // block_number[31:0]
	input  wire logic                   s_axis_tuser,   // action[0]
	// result word
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // found[0], position[6:1],
	                                                    // add_ok[7], entries_held[14:8], 0[15]
	// capacity register
	input  wire logic                   cfg_wr_en,
	input  wire logic [CAP_W-1:0]       cfg_wr_data
);

	logic [CAP_W-1:0]       cap_q;
	logic [CMP_W-1:0]       cap_ext;
	logic [CNT_W-1:0]       limit;
	logic                   eng_idle;
	logic                   eng_done;
	logic                   out_free;
	logic                   start;
	res_t                   eng_res;
	logic                   m_valid_q;
	res_t                   m_res_q;

	// capacity register; the limit taken from it is saturated to the table depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	assign cap_ext = CMP_W'(cap_q);
	assign limit   = (cap_ext > CMP_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
	                                                 : CNT_W'(cap_ext);

	// request handshake: engine takes a word only when idle
	assign s_axis_tready = eng_idle;
	assign start         = s_axis_tvalid && eng_idle;

	// output register is free when empty or being drained this cycle
	assign out_free = !m_valid_q || m_axis_tready;

	sblt_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.op       (s_axis_tuser),
		.item_in  ($signed(s_axis_tdata)),
		.limit    (limit),
		.out_free (out_free),
		.idle     (eng_idle),
		.done     (eng_done),
		.res      (eng_res)
	);

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (eng_done) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_done) begin
			m_res_q <= eng_res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_res_q.entries_held, m_res_q.add_ok,
	                        m_res_q.position, m_res_q.found};

endmodule

`default_nettype wire

// File: rtl/sblt_cmp.sv
`default_nettype none

module sblt_cmp
	import sblt_pkg::*;
(
	input  wire logic signed [DATA_W-1:0] entry,
	input  wire logic signed [DATA_W-1:0] key,
	output logic                          eq,
	output logic                          lt
);

	// signed compare shared by search and insert
	assign eq = (entry == key);
	assign lt = (entry < key);

endmodule

`default_nettype wire

// File: rtl/sblt_engine.sv
`default_nettype none

module sblt_engine
	import sblt_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic                     op,
	input  wire logic signed [DATA_W-1:0] item_in,
	input  wire logic [CNT_W-1:0]         limit,
	input  wire logic                     out_free,
	output logic                          idle,
	output logic                          done,
	output res_t                          res
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_PLACE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t                    state_q;
	logic                      op_q;
	logic signed [DATA_W-1:0]  item_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          iss_q;
	logic                      pv_q;
	logic [IDX_W-1:0]          pidx_q;
	logic [IDX_W-1:0]          slot_q;
	logic [CNT_W-1:0]          rem_q;
	logic [IDX_W-1:0]          rd_ptr_q;
	logic                      wv_q;
	logic [IDX_W-1:0]          wa_q;
	logic                      found_q;
	logic [IDX_W-1:0]          pos_q;
	logic                      ok_q;

	logic signed [DATA_W-1:0]  mem [TABLE_DEPTH];
	logic signed [DATA_W-1:0]  rdata_q;

	logic                      issue_scan;
	logic                      issue_shift;
	logic                      last_scan;
	logic                      hit_eq;
	logic                      hit_lt;
	logic [IDX_W-1:0]          rd_addr;
	logic                      mem_we;
	logic [IDX_W-1:0]          mem_wa;
	logic signed [DATA_W-1:0]  mem_wd;

	sblt_cmp u_cmp (
		.entry (rdata_q),
		.key   (item_q),
		.eq    (hit_eq),
		.lt    (hit_lt)
	);

	assign issue_scan  = (state_q == ST_SCAN) && (iss_q < count_q);
	assign issue_shift = (state_q == ST_SHIFT) && (rem_q != '0);
	assign last_scan   = (CNT_W'(pidx_q) == (count_q - 1'b1));
	assign rd_addr     = (state_q == ST_SHIFT) ? rd_ptr_q : iss_q[IDX_W-1:0];

	// single write port: shift moves, then the final placement
	always_comb begin
		mem_we = 1'b0;
		mem_wa = wa_q;
		mem_wd = rdata_q;
		if (state_q == ST_SHIFT && wv_q) begin
			mem_we = 1'b1;
		end else if (state_q == ST_PLACE) begin
			mem_we = 1'b1;
			mem_wa = slot_q;
			mem_wd = item_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= ACT_FIND;
			item_q   <= '0;
			count_q  <= '0;
			iss_q    <= '0;
			pv_q     <= 1'b0;
			pidx_q   <= '0;
			slot_q   <= '0;
			rem_q    <= '0;
			rd_ptr_q <= '0;
			wv_q     <= 1'b0;
			wa_q     <= '0;
			found_q  <= 1'b0;
			pos_q    <= '0;
			ok_q     <= 1'b0;
		end else begin
			pv_q <= 1'b0;
			wv_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q    <= op;
						item_q  <= item_in;
						found_q <= 1'b0;
						pos_q   <= '0;
						ok_q    <= 1'b0;
						iss_q   <= '0;
						if (op == ACT_ADD && count_q >= limit) begin
							state_q <= ST_DONE;
						end else if (count_q == '0) begin
							slot_q  <= '0;
							state_q <= (op == ACT_ADD) ? ST_PLACE : ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue_scan) begin
						iss_q <= iss_q + 1'b1;
					end
					pv_q   <= issue_scan;
					pidx_q <= iss_q[IDX_W-1:0];
					if (pv_q) begin
						if (op_q == ACT_FIND) begin
							if (hit_eq) begin
								found_q <= 1'b1;
								pos_q   <= pidx_q;
								state_q <= ST_DONE;
							end else if (last_scan) begin
								state_q <= ST_DONE;
							end
						end else begin
							if (!hit_lt) begin
								if (hit_eq) begin
									ok_q    <= 1'b1;
									state_q <= ST_DONE;
								end else begin
									slot_q   <= pidx_q;
									rem_q    <= count_q - CNT_W'(pidx_q);
									rd_ptr_q <= IDX_W'(count_q - 1'b1);
									state_q  <= ST_SHIFT;
								end
							end else if (last_scan) begin
								slot_q  <= count_q[IDX_W-1:0];
								state_q <= ST_PLACE;
							end
						end
					end
				end
				ST_SHIFT: begin
					// read at rd_ptr, write it one slot up in the following cycle
					if (issue_shift) begin
						rd_ptr_q <= rd_ptr_q - 1'b1;
						rem_q    <= rem_q - 1'b1;
					end
					wv_q <= issue_shift;
					wa_q <= rd_ptr_q + 1'b1;
					if (rem_q == '0 && !wv_q) begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					count_q <= count_q + 1'b1;
					ok_q    <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE) && out_free;

	assign res.found        = found_q;
	assign res.position     = POS_W'(pos_q);
	assign res.add_ok       = ok_q;
	assign res.entries_held = HELD_W'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PLACE) |=> (count_q == $past(count_q) + 1'b1))
		else $error("placement did not grow the table by one");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_PLACE) |=> (count_q == $past(count_q)))
		else $error("entry count changed outside placement");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && pv_q) |-> (CNT_W'(pidx_q) < count_q))
		else $error("scan compared an entry beyond the count");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (ok_q || !found_q || op_q == ACT_FIND))
		else $error("add result carries a find hit");

endmodule

`default_nettype wire
